// File: design/ctxm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctxm_pkg
// Shared types and constants for the CAN transmit mailbox manager.
// ----------------------------------------------------------------------------
package ctxm_pkg;

   localparam int NUM_BUFFERS_DEF = 3;
   localparam int MAX_BUFFERS     = 8;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [3:0]  DLC_MAX       = 4'd8;
   localparam logic [7:0]  SIDL_IDE      = 8'h08;
   localparam logic [7:0]  DLC_RTR       = 8'h40;

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_SEND  = 3'd1,
      OP_CLEAR = 3'd2,
      OP_TICK  = 3'd3,
      OP_QUERY = 3'd4
   } ctxm_op_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  buffer_index;
      logic [1:0]  priority_req;
      logic        id_extended;
      logic [28:0] can_id;
      logic [3:0]  dlc_code;
      logic        remote_frame;
   } ctxm_req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  reg_sidh;
      logic [7:0]  reg_sidl;
      logic [7:0]  reg_eid8;
      logic [7:0]  reg_eid0;
      logic [7:0]  reg_dlc;
      logic [1:0]  priority_out;
      logic        write_body;
      logic [2:0]  free_index;
      logic [7:0]  expired_mask;
   } ctxm_rsp_type;

   // packed header bytes plus format check of a load
   typedef struct packed {
      logic        fmt_ok;
      logic [7:0]  sidh;
      logic [7:0]  sidl;
      logic [7:0]  eid8;
      logic [7:0]  eid0;
      logic [7:0]  dlc;
      logic        write_body;
   } ctxm_hdr_type;

endpackage
`default_nettype wire

// File: design/ctxm_hdr_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctxm_hdr_pack
// Checks identifier and DLC of a load and packs the header register bytes.
// ----------------------------------------------------------------------------
module ctxm_hdr_pack
   import ctxm_pkg::*;
(
   input  ctxm_req_type req,
   output ctxm_hdr_type hdr
);

   logic std_ok;
   logic dlc_ok;

   assign std_ok = req.id_extended || (req.can_id[28:11] == 18'd0);
   assign dlc_ok = (req.dlc_code <= DLC_MAX);

   always_comb begin
      hdr        = '0;
      hdr.fmt_ok = std_ok && dlc_ok;
      if (req.id_extended) begin
         hdr.sidh = req.can_id[28:21];
         hdr.sidl = {req.can_id[20:18], 5'b0} | SIDL_IDE | {6'b0, req.can_id[17:16]};
         hdr.eid8 = req.can_id[15:8];
         hdr.eid0 = req.can_id[7:0];
      end else begin
         hdr.sidh = req.can_id[10:3];
         hdr.sidl = {req.can_id[2:0], 5'b0};
      end
      hdr.dlc        = {4'b0, req.dlc_code} | (req.remote_frame ? DLC_RTR : 8'h00);
      hdr.write_body = !req.remote_frame && (req.dlc_code != 4'd0);
   end

endmodule
`default_nettype wire

// File: design/can_tx_mailbox_manager_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_tx_mailbox_manager_top
// Tracks free flags and send timeouts of the CAN transmit buffers, validates
// and packs load requests, and answers send, clear, tick and query requests.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy never rises, so one
// request per cycle is sustained. Each request gives exactly one result,
// strobed on rsp_valid once it has passed the input register and then the
// result register, where the decode and buffer-state update land. The
// receiver cannot stall, so rsp_data must be captured in the
// strobe cycle. Buffer state updates in request order, so back-to-back
// requests always see the effect of the one before.
module can_tx_mailbox_manager_top
   import ctxm_pkg::*;
#(
   parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctxm_req_type req_data,
   output logic         rsp_valid,
   output ctxm_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   logic                   req_valid_ff;
   ctxm_req_type           req_ff;
   logic                   rsp_valid_ff;
   ctxm_rsp_type           rsp_ff;
   ctxm_rsp_type           rsp_in;
   logic [15:0]            timeout_ticks_ff;
   logic [NUM_BUFFERS-1:0] buffer_free_ff;
   logic [NUM_BUFFERS-1:0] buffer_free_in;
   logic [NUM_BUFFERS-1:0] timer_running_ff;
   logic [NUM_BUFFERS-1:0] timer_running_in;
   logic [15:0]            timeout_count_ff [NUM_BUFFERS];
   logic [15:0]            timeout_count_in [NUM_BUFFERS];

   logic [NUM_BUFFERS-1:0] sel;
   logic                   idx_ok;
   logic                   idx_free;
   logic [2:0]             low_free;
   logic                   none_free;
   ctxm_hdr_type           hdr;

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ctxm_hdr_pack u_hdr_pack (
      .req (req_ff),
      .hdr (hdr)
   );

   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         sel[i] = (req_ff.buffer_index == 3'(i));
      end
   end

   assign idx_ok   = (int'(req_ff.buffer_index) < NUM_BUFFERS);
   assign idx_free = |(sel & buffer_free_ff);

   // lowest free buffer
   always_comb begin
      low_free  = 3'(NUM_BUFFERS);
      none_free = 1'b1;
      for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
         if (buffer_free_ff[i]) begin
            low_free  = 3'(i);
            none_free = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in           = '0;
      buffer_free_in   = buffer_free_ff;
      timer_running_in = timer_running_ff;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         timeout_count_in[i] = timeout_count_ff[i];
      end
      if (req_valid_ff) begin
         unique case (req_ff.req_type)
            OP_LOAD: begin
               if (!idx_ok || !idx_free || !hdr.fmt_ok) begin
                  rsp_in.status = 1'b1;
               end else begin
                  rsp_in.reg_sidh     = hdr.sidh;
                  rsp_in.reg_sidl     = hdr.sidl;
                  rsp_in.reg_eid8     = hdr.eid8;
                  rsp_in.reg_eid0     = hdr.eid0;
                  rsp_in.reg_dlc      = hdr.dlc;
                  rsp_in.priority_out = req_ff.priority_req;
                  rsp_in.write_body   = hdr.write_body;
               end
            end
            OP_SEND: begin
               if (!idx_ok || !idx_free) begin
                  rsp_in.status = 1'b1;
               end else begin
                  for (int i = 0; i < NUM_BUFFERS; i++) begin
                     if (sel[i]) begin
                        buffer_free_in[i]   = 1'b0;
                        timer_running_in[i] = 1'b1;
                        timeout_count_in[i] = timeout_ticks_ff;
                     end
                  end
               end
            end
            OP_CLEAR: begin
               if (!idx_ok) begin
                  rsp_in.status = 1'b1;
               end else begin
                  for (int i = 0; i < NUM_BUFFERS; i++) begin
                     if (sel[i]) begin
                        buffer_free_in[i]   = 1'b1;
                        timer_running_in[i] = 1'b0;
                        timeout_count_in[i] = 16'd0;
                     end
                  end
               end
            end
            OP_TICK: begin
               // a count of 0 or 1 expires on this tick
               for (int i = 0; i < NUM_BUFFERS; i++) begin
                  if (timer_running_ff[i]) begin
                     if (timeout_count_ff[i] <= 16'd1) begin
                        timeout_count_in[i]    = 16'd0;
                        timer_running_in[i]    = 1'b0;
                        buffer_free_in[i]      = 1'b1;
                        rsp_in.expired_mask[i] = 1'b1;
                     end else begin
                        timeout_count_in[i] = timeout_count_ff[i] - 16'd1;
                     end
                  end
               end
            end
            OP_QUERY: begin
               rsp_in.status     = none_free;
               rsp_in.free_index = low_free;
            end
            default: begin
               rsp_in.status = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         timeout_ticks_ff <= TIMEOUT_RESET;
         buffer_free_ff   <= '1;
         timer_running_ff <= '0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            timeout_count_ff[i] <= 16'd0;
         end
      end else begin
         req_valid_ff     <= start && !busy;
         rsp_valid_ff     <= req_valid_ff;
         buffer_free_ff   <= buffer_free_in;
         timer_running_ff <= timer_running_in;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            timeout_count_ff[i] <= timeout_count_in[i];
         end
         if (csr_wr_en) begin
            timeout_ticks_ff <= csr_wr_data;
         end
      end
   end

   // every accepted request is answered by a result strobe
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("request transfer without a result two cycles later");

   // no result without an accepted request before it
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2) && !$past(busy, 2))
      else $error("result strobe without a request");

   // a failed request never carries header bytes or expiries
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.reg_sidh == 8'd0 && rsp_data.reg_dlc == 8'd0 &&
         rsp_data.expired_mask == 8'd0 && !rsp_data.write_body)
      else $error("failed result carries payload");

   // a buffer reported as expired is free once the result is shown
   a_expired_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.expired_mask & ~8'(buffer_free_ff)) == 8'd0)
      else $error("expired buffer not freed");

endmodule
`default_nettype wire

// File: test/can_tx_mailbox_manager_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_tx_mailbox_manager_top_tb
// Drives load, send, clear, tick and query requests into the mailbox manager.
// Each reply is checked field by field against a cycle-free model of the
// buffer flags and timeout counters. The run covers several timeout settings.
// ----------------------------------------------------------------------------
module can_tx_mailbox_manager_top_tb;
   import ctxm_pkg::*;

   localparam int NUM_BUF      = NUM_BUFFERS_DEF;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int CALM_FIRST   = 1700;
   localparam int CALM_LAST    = 1900;
   localparam logic [28:0] STD_ID_MAX = 29'd2047;
   localparam logic [28:0] EXT_ID_MAX = 29'h1FFF_FFFF;
   // request codes with no operation behind them
   localparam logic [2:0] OP_RSVD_A = 3'd5;
   localparam logic [2:0] OP_RSVD_B = 3'd6;
   localparam logic [2:0] OP_RSVD_C = 3'd7;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         start       = 1'b0;
   logic         busy;
   ctxm_req_type req_data    = '0;
   logic         rsp_valid;
   ctxm_rsp_type rsp_data;
   logic         csr_wr_en   = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   ctxm_req_type mbx_requests [$];
   ctxm_rsp_type due_replies [$];
   logic         req_taken    = 1'b0;
   int           issued_cnt   = 0;
   int           quiet_cycles = 0;
   int           mismatch_cnt = 0;

   // mirror of the block's buffer state
   logic         buf_free  [NUM_BUF];
   logic [15:0]  tmo_count [NUM_BUF];
   logic         tmo_armed [NUM_BUF];
   logic [15:0]  tmo_ticks;

   can_tx_mailbox_manager_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic ctxm_req_type mk_req(logic [2:0] op, logic [2:0] idx, logic [1:0] prio,
                                           logic ext, logic [28:0] id, logic [3:0] dlc,
                                           logic rtr);
      ctxm_req_type r;
      r.req_type     = op;
      r.buffer_index = idx;
      r.priority_req = prio;
      r.id_extended  = ext;
      r.can_id       = id;
      r.dlc_code     = dlc;
      r.remote_frame = rtr;
      return r;
   endfunction

   // any op, unused fields random
   function automatic ctxm_req_type any_req(logic [2:0] op, logic [2:0] idx);
      return mk_req(op, idx, 2'($urandom_range(3)), 1'($urandom_range(1)),
                    29'($urandom_range(EXT_ID_MAX)), 4'($urandom_range(15)),
                    1'($urandom_range(1)));
   endfunction

   // Applies one request to the mirrored state and returns the reply it causes.
   function automatic ctxm_rsp_type mailbox_reply(ctxm_req_type r);
      ctxm_rsp_type rsp;
      int           found;
      logic         idx_ok;
      rsp    = '0;
      found  = NUM_BUF;
      idx_ok = r.buffer_index < NUM_BUF;
      case (r.req_type)
         OP_LOAD: begin
            if (!idx_ok || !buf_free[r.buffer_index] ||
                (!r.id_extended && r.can_id > STD_ID_MAX) || r.dlc_code > DLC_MAX) begin
               rsp.status = 1'b1;
            end else begin
               if (!r.id_extended) begin
                  rsp.reg_sidh = r.can_id[10:3];
                  rsp.reg_sidl = {r.can_id[2:0], 5'b0};
               end else begin
                  rsp.reg_sidh = r.can_id[28:21];
                  rsp.reg_sidl = {r.can_id[20:18], 5'b0} | SIDL_IDE |
                                 {6'b0, r.can_id[17:16]};
                  rsp.reg_eid8 = r.can_id[15:8];
                  rsp.reg_eid0 = r.can_id[7:0];
               end
               rsp.reg_dlc      = {4'b0, r.dlc_code} | (r.remote_frame ? DLC_RTR : 8'h00);
               rsp.priority_out = r.priority_req;
               rsp.write_body   = !r.remote_frame && r.dlc_code != 0;
            end
         end
         OP_SEND: begin
            if (!idx_ok || !buf_free[r.buffer_index]) begin
               rsp.status = 1'b1;
            end else begin
               buf_free[r.buffer_index]  = 1'b0;
               tmo_count[r.buffer_index] = tmo_ticks;
               tmo_armed[r.buffer_index] = 1'b1;
            end
         end
         OP_CLEAR: begin
            if (!idx_ok) begin
               rsp.status = 1'b1;
            end else begin
               buf_free[r.buffer_index]  = 1'b1;
               tmo_armed[r.buffer_index] = 1'b0;
               tmo_count[r.buffer_index] = '0;
            end
         end
         OP_TICK: begin
            for (int i = 0; i < NUM_BUF; i++) begin
               if (tmo_armed[i]) begin
                  // a count of zero expires as if it were one
                  if (tmo_count[i] <= 1) begin
                     tmo_count[i] = '0;
                     tmo_armed[i] = 1'b0;
                     buf_free[i]  = 1'b1;
                     rsp.expired_mask[i] = 1'b1;
                  end else begin
                     tmo_count[i] = tmo_count[i] - 1'b1;
                  end
               end
            end
         end
         OP_QUERY: begin
            for (int i = NUM_BUF - 1; i >= 0; i--)
               if (buf_free[i]) found = i;
            rsp.status     = found >= NUM_BUF;
            rsp.free_index = found[2:0];
         end
         default: begin
            rsp.status = 1'b1;
         end
      endcase
      return rsp;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_cnt++;
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!start || req_taken)) begin
         if (mbx_requests.size() != 0 &&
             ((issued_cnt >= CALM_FIRST && issued_cnt < CALM_LAST) ||
              $urandom_range(99) >= 36)) begin
            req_data <= mbx_requests.pop_front();
            start    <= 1'b1;
            issued_cnt++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // transfer monitor, reply checker and watchdog
   always @(posedge clock) begin
      ctxm_rsp_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= start && !busy;
         if (start && !busy)
            due_replies.push_back(mailbox_reply(req_data));
         if (rsp_valid) begin
            if (due_replies.size() == 0) begin
               $error("reply with no request outstanding");
               mismatch_cnt++;
            end else begin
               want = due_replies.pop_front();
               check_field("status",       8'(want.status),       8'(rsp_data.status));
               check_field("reg_sidh",     want.reg_sidh,         rsp_data.reg_sidh);
               check_field("reg_sidl",     want.reg_sidl,         rsp_data.reg_sidl);
               check_field("reg_eid8",     want.reg_eid8,         rsp_data.reg_eid8);
               check_field("reg_eid0",     want.reg_eid0,         rsp_data.reg_eid0);
               check_field("reg_dlc",      want.reg_dlc,          rsp_data.reg_dlc);
               check_field("priority_out", 8'(want.priority_out), 8'(rsp_data.priority_out));
               check_field("write_body",   8'(want.write_body),   8'(rsp_data.write_body));
               check_field("free_index",   8'(want.free_index),   8'(rsp_data.free_index));
               check_field("expired_mask", want.expired_mask,     rsp_data.expired_mask);
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic wait_drained();
      do
         @(negedge clock);
      while (mbx_requests.size() != 0 || start || due_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_timeout(logic [15:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      tmo_ticks    = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly load-then-send pairs with ticks, clears and queries; the rest noise
   task automatic fill_random(int count);
      int          pushed;
      int          pick;
      logic [2:0]  idx;
      logic        ext;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(99);
         idx  = 3'($urandom_range(NUM_BUF - 1));
         ext  = 1'($urandom_range(1));
         if (pick < 30) begin
            mbx_requests.push_back(mk_req(OP_LOAD, idx, 2'($urandom_range(3)), ext,
                                          ext ? 29'($urandom_range(EXT_ID_MAX))
                                              : 29'($urandom_range(STD_ID_MAX)),
                                          4'($urandom_range(DLC_MAX)),
                                          1'($urandom_range(1))));
            mbx_requests.push_back(any_req(OP_SEND, idx));
            pushed += 2;
         end else if (pick < 55) begin
            repeat ($urandom_range(1, 4)) begin
               mbx_requests.push_back(any_req(OP_TICK, 3'($urandom_range(7))));
               pushed++;
            end
         end else if (pick < 67) begin
            mbx_requests.push_back(any_req(OP_CLEAR, idx));
            pushed++;
         end else if (pick < 77) begin
            mbx_requests.push_back(any_req(OP_QUERY, 3'($urandom_range(7))));
            pushed++;
         end else begin
            mbx_requests.push_back(any_req(3'($urandom_range(7)), 3'($urandom_range(7))));
            pushed++;
         end
      end
   endtask

   initial begin
      logic [15:0] phase_tmo [8];
      tmo_ticks = TIMEOUT_RESET;
      for (int i = 0; i < NUM_BUF; i++) begin
         buf_free[i]  = 1'b1;
         tmo_count[i] = '0;
         tmo_armed[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes and failure cases at the reset timeout
      mbx_requests.push_back(mk_req(OP_LOAD, 0, 0, 0, 0, 0, 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 1, 3, 0, STD_ID_MAX, DLC_MAX, 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 2, 2, 1, EXT_ID_MAX, DLC_MAX, 1));
      mbx_requests.push_back(mk_req(OP_LOAD, 0, 1, 1, 0, 1, 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 0, 1, 0, 29'(STD_ID_MAX + 1), 2, 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 1, 0, 0, 29'h155, 4'(DLC_MAX + 1), 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 1, 0, 1, 29'h0AAA_AAAA, 4'hF, 1));
      mbx_requests.push_back(mk_req(OP_LOAD, 3'(NUM_BUF), 0, 0, 1, 1, 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 7, 0, 0, 1, 1, 0));
      mbx_requests.push_back(any_req(OP_RSVD_A, 0));
      mbx_requests.push_back(any_req(OP_RSVD_B, 1));
      mbx_requests.push_back(any_req(OP_RSVD_C, 7));
      mbx_requests.push_back(any_req(OP_QUERY, 0));
      mbx_requests.push_back(any_req(OP_SEND, 0));
      mbx_requests.push_back(any_req(OP_SEND, 0));
      mbx_requests.push_back(mk_req(OP_LOAD, 0, 0, 0, 5, 3, 0));
      mbx_requests.push_back(any_req(OP_SEND, 3'(NUM_BUF)));
      mbx_requests.push_back(any_req(OP_SEND, 1));
      mbx_requests.push_back(any_req(OP_SEND, 2));
      mbx_requests.push_back(any_req(OP_QUERY, 0));
      mbx_requests.push_back(any_req(OP_TICK, 0));
      mbx_requests.push_back(any_req(OP_CLEAR, 1));
      mbx_requests.push_back(any_req(OP_CLEAR, 1));
      mbx_requests.push_back(any_req(OP_CLEAR, 7));
      mbx_requests.push_back(any_req(OP_QUERY, 0));
      mbx_requests.push_back(any_req(OP_CLEAR, 0));
      mbx_requests.push_back(any_req(OP_CLEAR, 2));
      // reset timeout: buffer 0 expires exactly on the last tick
      mbx_requests.push_back(any_req(OP_SEND, 0));
      repeat (TIMEOUT_RESET)
         mbx_requests.push_back(any_req(OP_TICK, 3'($urandom_range(7))));

      phase_tmo = '{16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd3,
                     16'($urandom_range(1, 16)), 16'd5, 16'($urandom_range(1, 65535))};
      foreach (phase_tmo[p]) begin
         write_timeout(phase_tmo[p]);
         fill_random(115);
      end

      wait_drained();
      if (mismatch_cnt == 0 && due_replies.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
design/ctxm_pkg.sv
design/ctxm_hdr_pack.sv
design/can_tx_mailbox_manager_top.sv
test/can_tx_mailbox_manager_top_tb.sv
